/* rtl/fshc_pkg.sv */
// Shared types, codes and constants for the fan setpoint hysteresis controller.
// No dependencies; every other file in rtl/ imports this package.
package fshc_pkg;

   localparam int TEMP_W  = 18;
   localparam int SPEED_W = 16;

   // Ramp step per poll, and reciprocal for the speed/40 deadband:
   // x / 40 == (x * 52429) >> 21 for every 16-bit x.
   localparam logic [SPEED_W-1:0] RAMP_STEP   = 16'd200;
   localparam logic [SPEED_W-1:0] DIV40_RECIP = 16'd52429;
   localparam int                 DIV40_SHIFT = 21;

   localparam logic [TEMP_W-1:0]  RAISE_RESET   = 18'd86000;
   localparam logic [TEMP_W-1:0]  LOWER_RESET   = 18'd84000;
   localparam logic [TEMP_W-1:0]  ENGAGE_RESET  = 18'd84000;
   localparam logic [TEMP_W-1:0]  RELEASE_RESET = 18'd74000;
   localparam logic [SPEED_W-1:0] FLOOR_RESET   = 16'd3500;
   localparam logic [SPEED_W-1:0] CEILING_RESET = 16'd5000;

   typedef enum logic [1:0] {
      MODE_AUTO = 2'd0,
      MODE_HIGH = 2'd1,
      MODE_FULL = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      CSR_RAISE   = 3'd0,
      CSR_LOWER   = 3'd1,
      CSR_ENGAGE  = 3'd2,
      CSR_RELEASE = 3'd3,
      CSR_FLOOR   = 3'd4,
      CSR_CEILING = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [TEMP_W-1:0]  raise_threshold;
      logic [TEMP_W-1:0]  lower_threshold;
      logic [TEMP_W-1:0]  engage_threshold;
      logic [TEMP_W-1:0]  release_threshold;
      logic [SPEED_W-1:0] speed_floor;
      logic [SPEED_W-1:0] speed_ceiling;
   } cfg_type;

   typedef struct packed {
      logic               temp_ok;
      logic [TEMP_W-1:0]  temperature;
      logic               rpm_ok;
      logic [SPEED_W-1:0] fan_speed;
   } sample_type;

   typedef struct packed {
      logic               engaged;
      logic [SPEED_W-1:0] target;
      mode_type           last_mode;
   } state_type;

   typedef struct packed {
      mode_type           drive_mode;
      logic               mode_changed;
      logic [SPEED_W-1:0] speed_target;
      logic               engaged_now;
   } result_type;

   typedef struct packed {
      logic       res_valid;
      result_type result;
      state_type  state_next;
   } step_type;

endpackage

/* rtl/fshc_csr_regs.sv */
// Configuration register bank: thresholds and speed limits.
// Depends on fshc_pkg for the register index codes and the cfg_type bundle.
module fshc_csr_regs
   import fshc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [2:0]          wr_index,
   input  logic [TEMP_W-1:0]   wr_data,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_RAISE:   cfg_in.raise_threshold   = wr_data;
            CSR_LOWER:   cfg_in.lower_threshold   = wr_data;
            CSR_ENGAGE:  cfg_in.engage_threshold  = wr_data;
            CSR_RELEASE: cfg_in.release_threshold = wr_data;
            CSR_FLOOR:   cfg_in.speed_floor       = wr_data[SPEED_W-1:0];
            CSR_CEILING: cfg_in.speed_ceiling     = wr_data[SPEED_W-1:0];
            default:     cfg_in = cfg_ff;  // drop writes past the last register
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.raise_threshold   <= RAISE_RESET;
         cfg_ff.lower_threshold   <= LOWER_RESET;
         cfg_ff.engage_threshold  <= ENGAGE_RESET;
         cfg_ff.release_threshold <= RELEASE_RESET;
         cfg_ff.speed_floor       <= FLOOR_RESET;
         cfg_ff.speed_ceiling     <= CEILING_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/fshc_step.sv */
// One poll step: engagement hysteresis, setpoint ramp with clamps, mode pick.
// Pure combinational; depends on fshc_pkg for the sample, state and result types.
module fshc_step
   import fshc_pkg::*;
(
   input  cfg_type    cfg,
   input  state_type  state,
   input  sample_type sample,
   output step_type   step
);

   logic                      engaged_next;
   logic                      do_raise;
   logic                      do_lower;
   logic [SPEED_W:0]          up_sum;
   logic [SPEED_W-1:0]        up_val;
   logic signed [SPEED_W+1:0] dn_diff;
   logic [SPEED_W-1:0]        dn_val;
   logic [SPEED_W-1:0]        cur;
   logic [2*SPEED_W-1:0]      recip_prod;
   logic [SPEED_W-1:0]        deadband;
   logic [SPEED_W-1:0]        full_limit;
   mode_type                  mode;

   always_comb begin
      // engage check first, release check wins if both hit
      engaged_next = (state.engaged | (sample.temperature > cfg.engage_threshold))
                   & ~(sample.temperature < cfg.release_threshold);
      do_raise = sample.temperature > cfg.raise_threshold;
      do_lower = sample.temperature < cfg.lower_threshold;

      up_sum = {1'b0, state.target} + {1'b0, RAMP_STEP};
      if (!do_raise) begin
         up_val = state.target;
      end else if (up_sum > {1'b0, cfg.speed_ceiling}) begin
         up_val = cfg.speed_ceiling;
      end else begin
         up_val = up_sum[SPEED_W-1:0];
      end

      // signed so a ramp below zero clamps to the floor instead of wrapping
      dn_diff = $signed({2'b00, up_val}) - $signed({2'b00, RAMP_STEP});
      if (dn_diff < $signed({2'b00, cfg.speed_floor})) begin
         dn_val = cfg.speed_floor;
      end else begin
         dn_val = dn_diff[SPEED_W-1:0];
      end

      cur = do_lower ? dn_val : up_val;

      recip_prod = {{SPEED_W{1'b0}}, cur} * {{SPEED_W{1'b0}}, DIV40_RECIP};
      deadband   = SPEED_W'(recip_prod >> DIV40_SHIFT);
      full_limit = cur - deadband;

      if (!engaged_next) begin
         mode = MODE_AUTO;
      end else if (sample.rpm_ok && (sample.fan_speed < full_limit)) begin
         mode = MODE_FULL;
      end else if (sample.rpm_ok && (sample.fan_speed > cur)) begin
         mode = MODE_HIGH;
      end else begin
         mode = state.last_mode;
      end

      step.res_valid           = sample.temp_ok;
      step.result.drive_mode   = mode;
      step.result.mode_changed = (mode != state.last_mode);
      step.result.speed_target = engaged_next ? cur : state.target;
      step.result.engaged_now  = engaged_next;

      // an invalid temperature leaves the state untouched
      if (sample.temp_ok) begin
         step.state_next.engaged   = engaged_next;
         step.state_next.target    = engaged_next ? cur : state.target;
         step.state_next.last_mode = mode;
      end else begin
         step.state_next = state;
      end
   end

endmodule

/* rtl/fan_setpoint_hysteresis_controller_top.sv */
// Top level: input register, controller state, result register, CSR bank.
// Depends on fshc_pkg, fshc_csr_regs and fshc_step.

// The block takes one poll sample per clock cycle unless the rsp side stalls,
// and returns its result through the input register, then the result register; a
// sample with temp_ok low is consumed and gives no rsp transfer. The rate is
// set by the state update loop, where engagement, setpoint and last mode are
// computed and written back to the state register so the next sample sees them.
// A stalled rsp side holds one result in the output register and one sample
// in the input register before req_tready drops. csr_ready is always high;
// write registers only while no sample is in flight.
module fan_setpoint_hysteresis_controller_top
   import fshc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // temperature[17:0], fan_speed[33:18], zero pad
   input  logic [1:0]  req_tuser,   // temp_ok[0], rpm_ok[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // drive_mode[1:0], mode_changed[2],
                                    // speed_target[18:3], engaged_now[19], zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [17:0] csr_data
);

   cfg_type    cfg;
   step_type   step;

   logic       in_valid_ff;
   logic       in_valid_in;
   sample_type in_ff;
   sample_type in_in;
   state_type  state_ff;
   state_type  state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;
   result_type rsp_in;
   logic       advance;
   logic       fire;

   assign csr_ready = 1'b1;

   fshc_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   fshc_step u_step (
      .cfg    (cfg),
      .state  (state_ff),
      .sample (in_ff),
      .step   (step)
   );

   always_comb begin
      advance    = !rsp_valid_ff || rsp_tready;
      req_tready = !in_valid_ff || advance;
      fire       = in_valid_ff && advance;

      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
      in_in       = in_ff;
      if (req_tvalid && req_tready) begin
         in_in.temp_ok     = req_tuser[0];
         in_in.temperature = req_tdata[17:0];
         in_in.rpm_ok      = req_tuser[1];
         in_in.fan_speed   = req_tdata[33:18];
      end

      state_in     = fire ? step.state_next : state_ff;
      rsp_valid_in = fire ? step.res_valid : (rsp_valid_ff && !rsp_tready);
      rsp_in       = (fire && step.res_valid) ? step.result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         state_ff.engaged   <= 1'b0;
         state_ff.target    <= CEILING_RESET;
         state_ff.last_mode <= MODE_AUTO;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff.engaged_now, rsp_ff.speed_target,
                        rsp_ff.mode_changed, rsp_ff.drive_mode};

`ifndef NO_ASSERTIONS
   a_auto_when_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.engaged_now |-> rsp_ff.drive_mode == MODE_AUTO)
      else $error("result released from control but mode is not auto");

   a_invalid_temp_holds_state: assert property (@(posedge clock) disable iff (reset)
      fire && !in_ff.temp_ok |=> $stable(state_ff))
      else $error("sample with invalid temperature changed the state");

   a_sample_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("queued sample lost while result side stalled");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !state_ff.engaged)
      else $error("result valid or engaged after reset");
`endif

endmodule

/* tb/tb_fan_setpoint_hysteresis_controller_top.sv */
// Self-checking testbench for fan_setpoint_hysteresis_controller_top: directed and random
// poll samples under several register settings, checked against an in-bench model.
// Depends on fshc_pkg and the RTL top level.
module tb_fan_setpoint_hysteresis_controller_top;
   timeunit 1ns;
   timeprecision 1ps;
   import fshc_pkg::*;

   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;
   localparam int TEMP_MAX     = 200000;
   localparam int SPEED_MAX    = 65535;
   localparam int RAMP_RPM     = 200;
   localparam int DEADBAND_DIV = 40;
   localparam int GAP_MAX      = 14;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_ITEMS  = 130;

   typedef struct {
      sample_type smp;
      bit         near_target;   // replace fan_speed with a value around the setpoint
   } poll_item_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // temperature[17:0], fan_speed[33:18], zero pad
   logic [1:0]  req_tuser;   // temp_ok[0], rpm_ok[1]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // drive_mode[1:0], mode_changed[2], speed_target[18:3],
                             // engaged_now[19], zero pad
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [17:0] csr_data;

   poll_item_type poll_q[$];
   result_type    expected_q[$];

   // controller model state and settings
   cfg_type    ctl_cfg;
   logic       ctl_engaged;
   logic [15:0] ctl_target;
   mode_type   ctl_mode;

   int errors;
   int req_gap;
   int rsp_stall;
   bit req_taken;
   bit rsp_taken;
   bit req_burst;
   bit rsp_burst;

   fan_setpoint_hysteresis_controller_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Advance the controller by one sample; returns 1 when the sample yields a result.
   function automatic bit advance_controller(input sample_type smp, output result_type res);
      int       cur;
      mode_type mode;
      mode = ctl_mode;
      res = '0;
      if (!smp.temp_ok)
         return 0;
      if (smp.temperature > ctl_cfg.engage_threshold)
         ctl_engaged = 1'b1;
      if (smp.temperature < ctl_cfg.release_threshold)
         ctl_engaged = 1'b0;
      if (ctl_engaged) begin
         cur = int'(ctl_target);
         if (smp.temperature > ctl_cfg.raise_threshold) begin
            cur = cur + RAMP_RPM;
            if (cur > int'(ctl_cfg.speed_ceiling))
               cur = int'(ctl_cfg.speed_ceiling);
         end
         if (smp.temperature < ctl_cfg.lower_threshold) begin
            cur = cur - RAMP_RPM;
            if (cur < int'(ctl_cfg.speed_floor))
               cur = int'(ctl_cfg.speed_floor);
         end
         ctl_target = cur[15:0];
         if (smp.rpm_ok && int'(smp.fan_speed) < cur - cur / DEADBAND_DIV)
            mode = MODE_FULL;
         else if (smp.rpm_ok && int'(smp.fan_speed) > cur)
            mode = MODE_HIGH;
      end else begin
         mode = MODE_AUTO;
      end
      res.drive_mode   = mode;
      res.mode_changed = (mode != ctl_mode);
      res.speed_target = ctl_target;
      res.engaged_now  = ctl_engaged;
      ctl_mode = mode;
      return 1;
   endfunction

   function automatic int draw_gap(inout bit burst);
      if ($urandom_range(0, 39) == 0)
         burst = !burst;
      return burst ? 0 : int'($urandom_range(0, GAP_MAX));
   endfunction

   // Speed just around the current setpoint: hits both deadband edges and the held band.
   function automatic logic [15:0] near_speed();
      int t;
      int s;
      t = int'(ctl_target);
      s = t + 2 - int'($urandom_range(0, t / DEADBAND_DIV + 4));
      if (s < 0)
         s = 0;
      if (s > SPEED_MAX)
         s = SPEED_MAX;
      return s[15:0];
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic queue_poll(input logic t_ok, input int temp, input logic r_ok,
                             input int speed, input bit near);
      poll_item_type it;
      it.smp.temp_ok     = t_ok;
      it.smp.temperature = temp[17:0];
      it.smp.rpm_ok      = r_ok;
      it.smp.fan_speed   = speed[15:0];
      it.near_target     = near;
      poll_q.push_back(it);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [17:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RAISE:   ctl_cfg.raise_threshold   = value;
         CSR_LOWER:   ctl_cfg.lower_threshold   = value;
         CSR_ENGAGE:  ctl_cfg.engage_threshold  = value;
         CSR_RELEASE: ctl_cfg.release_threshold = value;
         CSR_FLOOR:   ctl_cfg.speed_floor       = value[15:0];
         CSR_CEILING: ctl_cfg.speed_ceiling     = value[15:0];
         default: ;
      endcase
   endtask

   // Wait until every sample is transferred and every result has come back.
   task automatic drain_block();
      do @(posedge clock); while (poll_q.size() != 0 || req_tvalid || expected_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_settings(input int phase);
      int rai, low, eng, rel, spd_lo, spd_hi;
      case (phase)
         0: begin
            rai = RAISE_RESET;  low = LOWER_RESET;
            eng = ENGAGE_RESET; rel = RELEASE_RESET;
            spd_lo = FLOOR_RESET; spd_hi = CEILING_RESET;
         end
         1: begin
            // both ramps for temperatures strictly inside 0..TEMP_MAX, never releases
            rai = 0; low = TEMP_MAX; eng = 0; rel = 0;
            spd_lo = 0; spd_hi = SPEED_MAX;
         end
         2: begin
            // floor above ceiling, overlapping ramp band
            rai = 60000; low = 90000; eng = 50000; rel = 40000;
            spd_lo = 6000; spd_hi = 2000;
         end
         3: begin
            rai = 0; low = TEMP_MAX; eng = 199000; rel = TEMP_MAX;
            spd_lo = SPEED_MAX; spd_hi = SPEED_MAX;
         end
         default: begin
            rel = $urandom_range(0, 150000);
            eng = rel + int'($urandom_range(0, 30000));
            low = rel + int'($urandom_range(0, 30000));
            rai = low + int'($urandom_range(0, 15000));
            spd_lo = $urandom_range(0, 60000);
            spd_hi = spd_lo + int'($urandom_range(0, 5535));
         end
      endcase
      write_csr(CSR_RAISE,   18'(rai));
      write_csr(CSR_LOWER,   18'(low));
      write_csr(CSR_ENGAGE,  18'(eng));
      write_csr(CSR_RELEASE, 18'(rel));
      // upper data bits of the speed registers must be dropped
      write_csr(CSR_FLOOR,   {2'($urandom_range(0, 3)), 16'(spd_lo)});
      write_csr(CSR_CEILING, {2'($urandom_range(0, 3)), 16'(spd_hi)});
      write_csr(phase[0] ? CSR_SPARE_LO : CSR_SPARE_HI, 18'($urandom));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Temperatures follow a mean-reverting walk around the engage/release band,
   // so engaged runs last long enough to ramp into the clamps.
   task automatic queue_random(input int count);
      int center, walk, temp, speed, pick, spd_lo, spd_hi;
      center = (int'(ctl_cfg.engage_threshold) + int'(ctl_cfg.release_threshold)) / 2;
      walk   = center;
      spd_lo = int'(ctl_cfg.speed_floor);
      spd_hi = int'(ctl_cfg.speed_ceiling);
      if (spd_lo > spd_hi) begin
         spd_lo = int'(ctl_cfg.speed_ceiling);
         spd_hi = int'(ctl_cfg.speed_floor);
      end
      spd_lo = (spd_lo > 300) ? spd_lo - 300 : 0;
      spd_hi = (spd_hi < SPEED_MAX - 300) ? spd_hi + 300 : SPEED_MAX;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            temp = $urandom_range(0, TEMP_MAX);
         end else if (pick < 14) begin
            case ($urandom_range(0, 3))
               0: temp = int'(ctl_cfg.raise_threshold);
               1: temp = int'(ctl_cfg.lower_threshold);
               2: temp = int'(ctl_cfg.engage_threshold);
               default: temp = int'(ctl_cfg.release_threshold);
            endcase
            temp = temp + int'($urandom_range(0, 2)) - 1;
         end else begin
            walk = walk + int'($urandom_range(0, 6000)) - 3000 + (center - walk) / 20;
            temp = walk;
         end
         if (temp < 0)
            temp = 0;
         if (temp > TEMP_MAX)
            temp = TEMP_MAX;
         if ($urandom_range(0, 4) == 0)
            speed = $urandom_range(0, SPEED_MAX);
         else
            speed = $urandom_range(spd_lo, spd_hi);
         queue_poll($urandom_range(0, 9) != 0, temp, $urandom_range(0, 7) != 0, speed,
                    $urandom_range(0, 2) == 0);
      end
   endtask

   // Driver: one sample per transfer, random gap before each.
   always @(negedge clock) begin
      poll_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap--;
         end else if (poll_q.size() > 0) begin
            it = poll_q.pop_front();
            if (it.near_target)
               it.smp.fan_speed = near_speed();
            req_tdata  <= {6'd0, it.smp.fan_speed, it.smp.temperature};
            req_tuser  <= {it.smp.rpm_ok, it.smp.temp_ok};
            req_tvalid <= 1'b1;
            req_gap = draw_gap(req_burst);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side back-pressure: new stall drawn after each transfer.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken)
            rsp_stall = draw_gap(rsp_burst);
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: predict on each sample transfer, compare on each result transfer.
   always @(posedge clock) begin
      sample_type smp;
      result_type res;
      result_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         rsp_taken <= rsp_tvalid && rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = expected_q.pop_front();
               check_field("drive_mode",   16'(want.drive_mode),   16'(rsp_tdata[1:0]));
               check_field("mode_changed", 16'(want.mode_changed), 16'(rsp_tdata[2]));
               check_field("speed_target", want.speed_target,      rsp_tdata[18:3]);
               check_field("engaged_now",  16'(want.engaged_now),  16'(rsp_tdata[19]));
            end
         end
         if (req_tvalid && req_tready) begin
            smp.temp_ok     = req_tuser[0];
            smp.rpm_ok      = req_tuser[1];
            smp.temperature = req_tdata[17:0];
            smp.fan_speed   = req_tdata[33:18];
            if (advance_controller(smp, res))
               expected_q.push_back(res);
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      errors     = 0;
      req_gap    = 0;
      rsp_stall  = 0;
      req_burst  = 1'b0;
      rsp_burst  = 1'b0;
      ctl_cfg.raise_threshold   = RAISE_RESET;
      ctl_cfg.lower_threshold   = LOWER_RESET;
      ctl_cfg.engage_threshold  = ENGAGE_RESET;
      ctl_cfg.release_threshold = RELEASE_RESET;
      ctl_cfg.speed_floor       = FLOOR_RESET;
      ctl_cfg.speed_ceiling     = CEILING_RESET;
      ctl_engaged = 1'b0;
      ctl_target  = CEILING_RESET;
      ctl_mode    = MODE_AUTO;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed walk through the reset settings
      queue_poll(1'b0, TEMP_MAX, 1'b1, SPEED_MAX, 1'b0);  // invalid: no result
      queue_poll(1'b1, 0, 1'b0, 0, 1'b0);
      queue_poll(1'b1, ENGAGE_RESET, 1'b1, 0, 1'b0);      // at engage: stays auto
      queue_poll(1'b1, ENGAGE_RESET + 1, 1'b1, 0, 1'b0);  // engage, full
      queue_poll(1'b1, TEMP_MAX, 1'b1, SPEED_MAX, 1'b0);  // raise into ceiling, high
      queue_poll(1'b1, RAISE_RESET, 1'b1, 4875, 1'b0);    // deadband edge: hold
      queue_poll(1'b1, RAISE_RESET, 1'b0, 0, 1'b0);       // speed invalid: hold
      queue_poll(1'b0, 0, 1'b1, 0, 1'b0);                 // invalid while engaged
      queue_poll(1'b1, LOWER_RESET - 1, 1'b1, 5000, 1'b0);
      repeat (7) queue_poll(1'b1, RELEASE_RESET, 1'b0, 0, 1'b0);  // ramp into floor
      queue_poll(1'b1, RELEASE_RESET, 1'b1, 3412, 1'b0);
      queue_poll(1'b1, RELEASE_RESET, 1'b1, 0, 1'b1);
      queue_poll(1'b1, RELEASE_RESET - 1, 1'b1, 0, 1'b0); // release
      queue_poll(1'b0, 100000, 1'b1, 0, 1'b0);
      queue_poll(1'b1, TEMP_MAX, 1'b1, SPEED_MAX, 1'b0);
      queue_poll(1'b1, TEMP_MAX, 1'b1, 0, 1'b1);
      drain_block();

      for (int phase = 0; phase < 7; phase++) begin
         program_settings(phase);
         queue_random(PHASE_ITEMS);
         drain_block();
      end

      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
